@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the buddy allocator.
// Depends on nothing; every user supplies clk and arst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define BTA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Consequent in the cycle after the antecedent.
`define BTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

@@ rtl/bta_pkg.sv @@
// Shared types, constants and helpers of the buddy tree allocator.
// Used by the top level and by its port checker; depends on nothing.
package bta_pkg;

	// Default region geometry.
	localparam int TOTAL_EXP_DEF = 16;
	localparam int BLOCK_EXP_DEF = 6;

	// Fixed field widths.
	localparam int VAL_W       = 5;
	localparam int REQ_W       = 32;
	localparam int OFF_W       = 16;
	localparam int USED_W      = 17;
	localparam int STATUS_W    = 2;
	localparam int EXP_W       = 6;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEM    = 2'd1,
		ST_ZERO_SIZE = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_EXP,
		S_ROOT,
		S_DOWN,
		S_CLIMB,
		S_MARK,
		S_UP,
		S_RESP
	} state_t;

	// Number of significant bits of a byte (0 for zero).
	function automatic logic [3:0] bitlen8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) n = 4'(i + 1);
		end
		return n;
	endfunction

endpackage

@@ rtl/bta_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read; a read of the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/buddy_tree_allocator.sv @@
// Allocate descends over the tree levels from the root to the granted block, marks it and updates
// its ancestors up to the root; free climbs over the nodes from the leaf of the freed offset to the
// first used node, marks it free and updates its ancestors, or answers when no used node is found.
// One item at a time: the next input beat is taken the cycle after the result is loaded.
// Reset: a clearing sweep writes all 2^(TOTAL_EXP-BLOCK_EXP+1)-1 nodes, one per cycle,
// with s_axis_tready low; the used total resets to zero.
module buddy_tree_allocator
	import bta_pkg::*;
#(
	parameter int TOTAL_EXP = TOTAL_EXP_DEF,
	parameter int BLOCK_EXP = BLOCK_EXP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // alloc_size[31:0], free_offset[47:32]
	input  logic                   s_axis_tuser,  // mode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // block_offset[15:0], used_bytes[32:16], zero
	output logic [STATUS_W-1:0]    m_axis_tuser   // status
);

	localparam int LEVELS = TOTAL_EXP - BLOCK_EXP;
	localparam int HW     = LEVELS + 1;
	localparam int NODES  = (1 << HW) - 1;
	localparam int PAD_W  = OUT_TDATA_W - USED_W - OFF_W;

	state_t state_q, state_d;

	// Control registers.
	logic [HW-1:0]     h_q;       // heap index (root is 1); sweep counter during clear
	logic [VAL_W-1:0]  cur_q;     // value just written on the current path
	logic [USED_W-1:0] used_q;
	logic              out_valid_q;

	// Payload registers.
	mode_t             mode_q;
	logic [REQ_W-1:0]  req_q;
	logic [OFF_W-1:0]  foff_q;
	logic [1:0]        bidx_q;
	logic [7:0]        byte_q;
	logic [EXP_W-1:0]  e_q;
	logic [EXP_W-1:0]  need_q;
	logic [VAL_W-1:0]  lvl_q;
	logic [LEVELS-1:0] pos_q;
	status_t           status_q;
	logic [OFF_W-1:0]  off_q;
	status_t           out_status_q;
	logic [OFF_W-1:0]  out_offset_q;
	logic [USED_W-1:0] out_used_q;

	// Memory port.
	logic              mem_we;
	logic [HW-1:0]     mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;
	logic [HW-1:0]     mem_raddr;
	logic [VAL_W-1:0]  mem_rdata;

	logic in_acc;
	logic out_load;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_load      = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);

	// Size rounding, first half: locate the top nonzero byte of the requested size minus one.
	logic [REQ_W-1:0] size_m1;
	logic [1:0]       sz_idx;
	logic [7:0]       sz_byte;

	assign size_m1 = req_q - REQ_W'(1);

	always_comb begin
		priority if (|size_m1[31:24]) begin
			sz_idx  = 2'd3;
			sz_byte = size_m1[31:24];
		end else if (|size_m1[23:16]) begin
			sz_idx  = 2'd2;
			sz_byte = size_m1[23:16];
		end else if (|size_m1[15:8]) begin
			sz_idx  = 2'd1;
			sz_byte = size_m1[15:8];
		end else begin
			sz_idx  = 2'd0;
			sz_byte = size_m1[7:0];
		end
	end

	// Size rounding, second half: exponent of the rounded block, at least the minimum block.
	logic [EXP_W-1:0] e_raw;
	logic [EXP_W-1:0] e_new;

	assign e_raw = EXP_W'({bidx_q, 3'b000}) + EXP_W'(bitlen8(byte_q));
	assign e_new = (e_raw < EXP_W'(BLOCK_EXP)) ? EXP_W'(BLOCK_EXP) : e_raw;

	// Leaf that covers the offset being freed.
	logic [TOTAL_EXP-1:0] foff_ext;
	logic [LEVELS-1:0]    leaf_pos;
	logic [HW-1:0]        leaf_h;

	assign foff_ext = TOTAL_EXP'(foff_q);
	assign leaf_pos = LEVELS'(foff_ext >> BLOCK_EXP);
	assign leaf_h   = {1'b1, leaf_pos};

	// Descent step: go right when the left child cannot hold the request.
	logic              fits;
	logic              go_right;
	logic [HW-1:0]     h_dn;
	logic [HW-1:0]     h_dn_child;
	logic [LEVELS-1:0] pos_dn;
	logic [VAL_W-1:0]  lvl_dn;

	assign fits       = (EXP_W'(mem_rdata) >= need_q);
	assign go_right   = (EXP_W'(mem_rdata) < need_q);
	assign h_dn       = HW'({h_q, go_right});
	assign h_dn_child = HW'({h_dn, 1'b0});
	assign pos_dn     = LEVELS'({pos_q, go_right});
	assign lvl_dn     = lvl_q - VAL_W'(1);

	// Ascent step: parent is the larger child, or one level up when both halves are free.
	logic [HW-1:0]     h_par;
	logic [VAL_W-1:0]  child_full;
	logic [VAL_W-1:0]  merged;
	logic [VAL_W-1:0]  mark_val;
	logic [USED_W-1:0] delta;

	assign h_par      = h_q >> 1;
	assign child_full = lvl_q + VAL_W'(1);
	assign merged     = (cur_q == child_full && mem_rdata == child_full) ?
	                    child_full + VAL_W'(1) :
	                    ((cur_q > mem_rdata) ? cur_q : mem_rdata);
	assign mark_val   = (mode_q == MODE_FREE) ? lvl_q + VAL_W'(1) : '0;
	assign delta      = {{(USED_W-1){1'b0}}, 1'b1} << lvl_q;

	// Byte offset of the granted block.
	logic [TOTAL_EXP-1:0] off_full;

	assign off_full = TOTAL_EXP'(pos_q) << lvl_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (&h_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) state_d = S_START;
			end
			S_START: begin
				if (mode_q == MODE_FREE) state_d = S_CLIMB;
				else if (req_q == '0) state_d = S_RESP;
				else state_d = S_EXP;
			end
			S_EXP: begin
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (!fits) state_d = S_RESP;
				else if (e_q == EXP_W'(TOTAL_EXP)) state_d = S_MARK;
				else state_d = S_DOWN;
			end
			S_DOWN: begin
				if (EXP_W'(lvl_dn) == e_q) state_d = S_MARK;
			end
			S_CLIMB: begin
				if (mem_rdata == '0) state_d = S_MARK;
				else if (h_q == HW'(1)) state_d = S_RESP;
			end
			S_MARK: begin
				state_d = (h_q == HW'(1)) ? S_RESP : S_UP;
			end
			S_UP: begin
				if (h_par == HW'(1)) state_d = S_RESP;
			end
			S_RESP: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = h_q - HW'(1);
		mem_wdata = cur_q;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_START: begin
				mem_raddr = leaf_h - HW'(1);
			end
			S_ROOT: begin
				mem_raddr = HW'(1);
			end
			S_DOWN: begin
				mem_raddr = h_dn_child - HW'(1);
			end
			S_CLIMB: begin
				mem_raddr = h_par - HW'(1);
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = mark_val;
				mem_raddr = (h_q ^ HW'(1)) - HW'(1);
			end
			S_UP: begin
				mem_we    = 1'b1;
				mem_waddr = h_par - HW'(1);
				mem_wdata = merged;
				mem_raddr = (h_par ^ HW'(1)) - HW'(1);
			end
			S_IDLE, S_EXP, S_RESP: begin
				mem_raddr = '0;
			end
			default: mem_raddr = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// Control registers: path index, current value, used total, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= HW'(1);
			cur_q       <= VAL_W'(TOTAL_EXP + 1);
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					h_q <= h_q + HW'(1);
					if ((h_q & (h_q + HW'(1))) == '0) cur_q <= cur_q - VAL_W'(1);
				end
				S_START: begin
					if (mode_q == MODE_FREE) h_q <= leaf_h;
				end
				S_ROOT: begin
					h_q <= HW'(1);
				end
				S_DOWN: begin
					h_q <= h_dn;
				end
				S_CLIMB: begin
					if (mem_rdata != '0 && h_q != HW'(1)) h_q <= h_par;
				end
				S_MARK: begin
					cur_q  <= mark_val;
					used_q <= (mode_q == MODE_FREE) ? used_q - delta : used_q + delta;
				end
				S_UP: begin
					h_q   <= h_par;
					cur_q <= merged;
				end
				S_IDLE, S_EXP, S_RESP: begin
					h_q <= h_q;
				end
				default: h_q <= h_q;
			endcase

			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mode_q <= mode_t'(s_axis_tuser);
					req_q  <= s_axis_tdata[REQ_W-1:0];
					foff_q <= s_axis_tdata[REQ_W +: OFF_W];
				end
			end
			S_START: begin
				bidx_q   <= sz_idx;
				byte_q   <= sz_byte;
				off_q    <= '0;
				lvl_q    <= VAL_W'(BLOCK_EXP);
				status_q <= (mode_q == MODE_ALLOC && req_q == '0) ? ST_ZERO_SIZE : ST_OK;
			end
			S_EXP: begin
				e_q    <= e_new;
				need_q <= e_new + EXP_W'(1);
			end
			S_ROOT: begin
				lvl_q <= VAL_W'(TOTAL_EXP);
				pos_q <= '0;
				if (!fits) status_q <= ST_NO_MEM;
			end
			S_DOWN: begin
				lvl_q <= lvl_dn;
				pos_q <= pos_dn;
			end
			S_CLIMB: begin
				if (mem_rdata != '0 && h_q != HW'(1)) lvl_q <= lvl_q + VAL_W'(1);
			end
			S_MARK: begin
				if (mode_q == MODE_ALLOC) off_q <= OFF_W'(off_full);
			end
			S_UP: begin
				lvl_q <= lvl_q + VAL_W'(1);
			end
			S_RESP: begin
				if (out_load) begin
					out_status_q <= status_q;
					out_offset_q <= off_q;
					out_used_q   <= used_q;
				end
			end
			S_CLEAR: begin
				off_q <= '0;
			end
			default: off_q <= off_q;
		endcase
	end

	// Node memory: per node, largest free exponent beneath it plus one, zero when full.
	bta_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NODES)
	) u_tree_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result beat.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_used_q, out_offset_q};
	assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/bta_checker.sv @@
// Port-level checks of the buddy tree allocator, bound to its top level.
// Depends on bta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bta_checker
	import bta_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,  // block_offset[15:0], used_bytes[32:16], zero
	input logic [STATUS_W-1:0]    m_axis_tuser   // status
);

	// One item at a time: the input closes right after a beat is taken.
	`BTA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A stalled result beat stays put.
	`BTA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// A request that does not end in ST_OK never reports a block offset.
	`BTA_ASSERT_SAME(a_offset_only_ok, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[OFF_W-1:0] == '0)

	// A new result only appears when the block was busy with an item.
	`BTA_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (.*);
